>>> hdl/fmil_pkg.sv
// shared types and constants of the fm-index locate engine
`default_nettype none
package fmil_pkg;

   localparam int unsigned MAX_LEN  = 65536;
   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned LEN_W    = 17;
   localparam int unsigned SYM_W    = 4;
   localparam int unsigned NUM_SYM  = 16;
   localparam int unsigned IVL_W    = 9;
   localparam int unsigned VAL_W    = 17;
   localparam int unsigned POS_W    = 16;

   localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LEN);

   typedef enum logic [1:0] {
      OP_WR_BWT  = 2'd0,
      OP_WR_CNT  = 2'd1,
      OP_WR_SAMP = 2'd2,
      OP_LOCATE  = 2'd3
   } op_type;

   localparam logic [1:0] REG_INTERVAL = 2'd0;
   localparam logic [1:0] REG_LENGTH   = 2'd1;
   localparam logic [1:0] REG_SENTINEL = 2'd2;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   index;
      logic [VAL_W-1:0]    value;
      logic                cnt_ok;
      logic                oob;
   } item_type;

   typedef struct packed {
      logic [IVL_W-1:0]    interval;
      logic [LEN_W-1:0]    len;
      logic [SYM_W-1:0]    sentinel;
      logic                changed;
   } cfg_type;

endpackage
`default_nettype wire

>>> hdl/fmil_front.sv
// front end: configuration registers, item acceptance and classification
`default_nettype none
module fmil_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [16:0]             csr_data,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [39:0]             req_tdata,
   input  wire logic [1:0]              req_tuser,
   input  wire logic                    q_full,
   output logic                         q_push,
   output fmil_pkg::item_type           q_item,
   output fmil_pkg::cfg_type            cfg
);
   logic [fmil_pkg::IVL_W-1:0] interval_ff;
   logic [fmil_pkg::LEN_W-1:0] length_ff;
   logic [fmil_pkg::SYM_W-1:0] sentinel_ff;
   logic                       csr_we;
   logic [fmil_pkg::LEN_W-1:0] len_eff;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= fmil_pkg::IVL_W'(32);
         length_ff   <= fmil_pkg::LEN_W'(1);
         sentinel_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            fmil_pkg::REG_INTERVAL: interval_ff <= csr_data[fmil_pkg::IVL_W-1:0];
            fmil_pkg::REG_LENGTH:   length_ff   <= csr_data;
            fmil_pkg::REG_SENTINEL: sentinel_ff <= csr_data[fmil_pkg::SYM_W-1:0];
            default: ;
         endcase
      end
   end

   assign len_eff = (length_ff > fmil_pkg::MAX_LEN_V) ? fmil_pkg::MAX_LEN_V : length_ff;

   always_comb begin
      cfg.interval = (interval_ff == '0) ? fmil_pkg::IVL_W'(1) : interval_ff;
      cfg.len      = len_eff;
      cfg.sentinel = sentinel_ff;
      cfg.changed  = csr_we && (csr_index == fmil_pkg::REG_INTERVAL ||
                                csr_index == fmil_pkg::REG_LENGTH);
   end

   // classify the transaction on its way into the queue
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_item.op     = fmil_pkg::op_type'(req_tuser);
      q_item.index  = req_tdata[15:0];
      q_item.value  = req_tdata[32:16];
      q_item.cnt_ok = (req_tdata[15:fmil_pkg::SYM_W] == '0);
      q_item.oob    = ({1'b0, req_tdata[15:0]} >= len_eff);
   end
endmodule
`default_nettype wire

>>> hdl/fmil_queue.sv
// two-entry item queue between front and back
`default_nettype none
module fmil_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire fmil_pkg::item_type   push_item,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output fmil_pkg::item_type        head_item
);
   fmil_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot_ff[rd_ptr_ff];
endmodule
`default_nettype wire

>>> hdl/fmil_back.sv
// back end: stores, rank sweep, lf-mapping walk and result register
`default_nettype none
module fmil_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fmil_pkg::cfg_type    cfg,
   input  wire logic                 head_valid,
   input  wire fmil_pkg::item_type   head_item,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,
   output logic                      rsp_tuser
);
   localparam int unsigned AUX_W = fmil_pkg::POS_W + 1 + fmil_pkg::LEN_W;

   typedef enum logic [2:0] {
      S_IDLE, S_SWEEP, S_RD, S_EVAL, S_POS, S_EMIT
   } state_type;

   typedef struct packed {
      logic [fmil_pkg::POS_W-1:0] quot;
      logic                       mark;
      logic [fmil_pkg::LEN_W-1:0] rank;
   } aux_type;

   logic [fmil_pkg::SYM_W-1:0] bwt_mem  [fmil_pkg::MAX_LEN];
   logic [AUX_W-1:0]           aux_mem  [fmil_pkg::MAX_LEN];
   logic [fmil_pkg::POS_W-1:0] samp_mem [fmil_pkg::MAX_LEN];
   logic [fmil_pkg::VAL_W-1:0] cnt_ff   [fmil_pkg::NUM_SYM];

   state_type                  state_ff, state_in;
   logic                       stale_ff;
   logic [fmil_pkg::ADDR_W-1:0] row_ff;
   logic [fmil_pkg::LEN_W-1:0] steps_ff;
   logic [fmil_pkg::LEN_W-1:0] sw_issue_ff;
   logic                       sw_vld_ff;
   logic [fmil_pkg::ADDR_W-1:0] sw_addr_ff;
   logic [fmil_pkg::LEN_W-1:0] seen_ff  [fmil_pkg::NUM_SYM];
   logic [fmil_pkg::IVL_W-1:0] mod_ff;
   logic [fmil_pkg::POS_W-1:0] quot_ff;
   logic [fmil_pkg::POS_W-1:0] res_pos_ff;
   logic                       res_oob_ff;
   logic                       rsp_valid_ff;
   logic [15:0]                rsp_data_ff;
   logic                       rsp_user_ff;

   logic [fmil_pkg::SYM_W-1:0] bwt_rd_ff;
   logic [AUX_W-1:0]           aux_rd_ff;
   logic [fmil_pkg::POS_W-1:0] samp_rd_ff;
   logic [fmil_pkg::ADDR_W-1:0] bwt_addr;
   logic                       bwt_we, cnt_we, samp_we, aux_we;
   logic                       samp_re;
   aux_type                    aux_q, aux_wd;
   logic [fmil_pkg::LEN_W-1:0] new_rank;
   logic [fmil_pkg::LEN_W:0]   lf_next;
   logic [fmil_pkg::LEN_W:0]   pos_sum;
   logic                       out_free;
   logic                       sw_issuing;

   assign aux_q      = aux_type'(aux_rd_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sw_issuing = (state_ff == S_SWEEP) && (sw_issue_ff < cfg.len);

   always_comb begin
      pop     = 1'b0;
      bwt_we  = 1'b0;
      cnt_we  = 1'b0;
      samp_we = 1'b0;
      if (state_ff == S_IDLE && head_valid) begin
         pop = 1'b1;
         unique case (head_item.op)
            fmil_pkg::OP_WR_BWT:  bwt_we  = 1'b1;
            fmil_pkg::OP_WR_CNT:  cnt_we  = head_item.cnt_ok;
            fmil_pkg::OP_WR_SAMP: samp_we = 1'b1;
            fmil_pkg::OP_LOCATE:  ;
            default: ;
         endcase
      end
   end

   assign bwt_addr = sw_issuing ? sw_issue_ff[fmil_pkg::ADDR_W-1:0] : row_ff;
   assign samp_re  = (state_ff == S_EVAL);
   assign aux_we   = (state_ff == S_SWEEP) && sw_vld_ff;

   // per-row rank, sample mark and sample slot built by the sweep
   assign new_rank = seen_ff[bwt_rd_ff] + fmil_pkg::LEN_W'(1);
   always_comb begin
      aux_wd.quot = quot_ff;
      aux_wd.mark = (mod_ff == '0);
      aux_wd.rank = new_rank;
   end

   always_ff @(posedge clock) begin
      if (bwt_we) begin
         bwt_mem[head_item.index] <= head_item.value[fmil_pkg::SYM_W-1:0];
      end
      bwt_rd_ff <= bwt_mem[bwt_addr];
   end

   always_ff @(posedge clock) begin
      if (aux_we) begin
         aux_mem[sw_addr_ff] <= AUX_W'(aux_wd);
      end
      aux_rd_ff <= aux_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (samp_we) begin
         samp_mem[head_item.index] <= head_item.value[fmil_pkg::POS_W-1:0];
      end
      if (samp_re) begin
         samp_rd_ff <= samp_mem[aux_q.quot];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_ff[head_item.index[fmil_pkg::SYM_W-1:0]] <= head_item.value;
      end
   end

   always_comb begin
      if (bwt_rd_ff == cfg.sentinel) begin
         lf_next = '0;
      end else begin
         lf_next = {1'b0, cnt_ff[bwt_rd_ff]} + {1'b0, aux_q.rank} - (fmil_pkg::LEN_W+1)'(1);
      end
   end

   assign pos_sum = {2'b00, samp_rd_ff} + {1'b0, steps_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid && head_item.op == fmil_pkg::OP_LOCATE) begin
               if (head_item.oob) begin
                  state_in = S_EMIT;
               end else if (stale_ff) begin
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_SWEEP: begin
            if (!sw_issuing && !sw_vld_ff) begin
               state_in = S_RD;
            end
         end
         S_RD: state_in = S_EVAL;
         S_EVAL: begin
            if (aux_q.mark) begin
               state_in = S_POS;
            end else if (steps_ff >= cfg.len || lf_next >= {1'b0, cfg.len}) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_RD;
            end
         end
         S_POS:  state_in = S_EMIT;
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         sw_vld_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg.changed || bwt_we) begin
            stale_ff <= 1'b1;
         end else if (state_ff == S_SWEEP && state_in == S_RD) begin
            stale_ff <= 1'b0;
         end
         sw_vld_ff <= sw_issuing;
         if (state_ff == S_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res_pos_ff;
            rsp_user_ff  <= res_oob_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            row_ff      <= head_item.index;
            steps_ff    <= '0;
            sw_issue_ff <= '0;
            mod_ff      <= '0;
            quot_ff     <= '0;
            res_pos_ff  <= '0;
            res_oob_ff  <= 1'b1;
            for (int i = 0; i < fmil_pkg::NUM_SYM; i++) begin
               seen_ff[i] <= '0;
            end
         end
         S_SWEEP: begin
            if (sw_issuing) begin
               sw_issue_ff <= sw_issue_ff + fmil_pkg::LEN_W'(1);
               sw_addr_ff  <= sw_issue_ff[fmil_pkg::ADDR_W-1:0];
            end
            if (sw_vld_ff) begin
               seen_ff[bwt_rd_ff] <= new_rank;
               if (mod_ff == cfg.interval - fmil_pkg::IVL_W'(1)) begin
                  mod_ff  <= '0;
                  quot_ff <= quot_ff + fmil_pkg::POS_W'(1);
               end else begin
                  mod_ff <= mod_ff + fmil_pkg::IVL_W'(1);
               end
            end
         end
         S_EVAL: begin
            if (!aux_q.mark) begin
               row_ff   <= lf_next[fmil_pkg::ADDR_W-1:0];
               steps_ff <= steps_ff + fmil_pkg::LEN_W'(1);
            end
         end
         S_POS: begin
            res_oob_ff <= 1'b0;
            if (pos_sum >= {1'b0, cfg.len}) begin
               res_pos_ff <= fmil_pkg::POS_W'(pos_sum - {1'b0, cfg.len});
            end else begin
               res_pos_ff <= pos_sum[fmil_pkg::POS_W-1:0];
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule
`default_nettype wire

>>> hdl/fm_index_locate.sv
// a store write is taken from the queue while the back end is idle; a locate walks
// up to text_length lf steps, one store read pair per step
// after a write to the bwt store, the length or the interval, the next locate first
// runs a rank sweep over the first text_length rows of the bwt store
// throughput: one item at a time in the back end, a two-entry queue in front
// reset: control state and registers to defaults, stores undefined until written
`default_nettype none
module fm_index_locate (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // index[15:0], value[32:16], zero fill
   input  wire logic [1:0]  req_tuser,  // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // text_position[15:0]
   output logic             rsp_tuser   // out_of_range
);
   fmil_pkg::cfg_type  cfg;
   fmil_pkg::item_type q_item, head_item;
   logic               q_full, q_push, pop, head_valid;

   fmil_front u_front (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .q_full, .q_push, .q_item, .cfg
   );

   fmil_queue u_queue (
      .clock, .reset,
      .push(q_push), .push_item(q_item), .full(q_full),
      .pop, .head_valid, .head_item
   );

   fmil_back u_back (
      .clock, .reset, .cfg,
      .head_valid, .head_item, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );
endmodule
`default_nettype wire

>>> bench/tb_fm_index_locate.sv
// self-checking testbench for the fm-index locate engine
`default_nettype none
module tb_fm_index_locate;

   typedef struct {
      fmil_pkg::op_type op;
      bit [15:0]        index;
      bit [16:0]        value;
   } req_type;

   typedef struct {
      bit [15:0] pos;
      bit        oob;
   } answer_type;

   localparam int unsigned CYCLE_LIMIT = 3000000;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [16:0] csr_data = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic rsp_tuser;

   fm_index_locate uut (.*);

   always #6 clock = ~clock;

   // predictor state
   bit [3:0]    bwt_mem  [0:65535];
   bit [16:0]   cnt_mem  [0:15];
   bit [15:0]   samp_mem [0:65535];
   int unsigned rank_of  [0:65535];
   bit          rank_dirty = 1;
   bit [8:0]    cfg_iv = 9'd32;
   bit [16:0]   cfg_len = 17'd1;
   bit [3:0]    cfg_sent = 4'd0;

   req_type    pending[$];
   answer_type expected_answers[$];
   req_type    cur_req;
   bit      req_taken = 0;
   bit      csr_taken = 0;
   bit      calm = 0;
   bit      held_once = 0;
   int      hold_left = 0;
   int      rsp_seen = 0;
   int      errors = 0;
   int unsigned cycles = 0;

   function automatic answer_type locate_answer(bit [15:0] start);
      answer_type a;
      int unsigned len, iv, row, steps, nxt, pos;
      int unsigned seen [16];
      bit [3:0] c;
      len = cfg_len > 65536 ? 65536 : cfg_len;
      iv = cfg_iv == 0 ? 1 : cfg_iv;
      a.pos = 0;
      a.oob = 1;
      if (start >= len) return a;
      if (rank_dirty) begin
         foreach (seen[k]) seen[k] = 0;
         for (int unsigned p = 0; p < len; p++) begin
            seen[bwt_mem[p]]++;
            rank_of[p] = seen[bwt_mem[p]];
         end
         rank_dirty = 0;
      end
      row = start;
      steps = 0;
      while (row % iv != 0) begin
         if (steps >= len) return a;
         c = bwt_mem[row];
         nxt = (c == cfg_sent) ? 0 : cnt_mem[c] + rank_of[row] - 1;
         steps++;
         if (nxt >= len) return a;
         row = nxt;
      end
      pos = samp_mem[(row / iv) % 65536] + steps;
      if (pos >= len) pos -= len;
      a.pos = pos[15:0];
      a.oob = 0;
      return a;
   endfunction

   task automatic apply_req(req_type r);
      case (r.op)
         fmil_pkg::OP_WR_BWT: begin
            bwt_mem[r.index] = r.value[3:0];
            rank_dirty = 1;
         end
         fmil_pkg::OP_WR_CNT: if (r.index < 16) cnt_mem[r.index] = r.value;
         fmil_pkg::OP_WR_SAMP: samp_mem[r.index] = r.value[15:0];
         fmil_pkg::OP_LOCATE: expected_answers.push_back(locate_answer(r.index));
      endcase
   endtask

   // accept side, monitor and watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("fm_index_locate: mismatch");
         $finish;
      end
      req_taken <= req_tvalid && req_tready;
      csr_taken <= csr_valid && csr_ready;
      if (!reset && req_tvalid && req_tready) apply_req(cur_req);
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            fmil_pkg::REG_INTERVAL: cfg_iv = csr_data[8:0];
            fmil_pkg::REG_LENGTH: begin
               cfg_len = csr_data;
               rank_dirty = 1;
            end
            fmil_pkg::REG_SENTINEL: cfg_sent = csr_data[3:0];
            default: ;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen <= rsp_seen + 1;
         if (expected_answers.size() == 0) begin
            $error("unexpected result text_position=%0d out_of_range=%0d",
                   rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            answer_type e;
            e = expected_answers.pop_front();
            if (rsp_tdata !== e.pos) begin
               $error("text_position expected %0d actual %0d", e.pos, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== e.oob) begin
               $error("out_of_range expected %0d actual %0d", e.oob, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // input driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
            cur_req = pending.pop_front();
            req_tvalid <= 1;
            req_tdata <= {7'b0, cur_req.value, cur_req.index};
            req_tuser <= cur_req.op;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // result receiver, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else if (!held_once && rsp_seen >= 60) begin
         held_once <= 1;
         hold_left <= 600;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= 18;
      end
   end

   task automatic push(fmil_pkg::op_type op, int unsigned idx, int unsigned val);
      req_type r;
      r.op = op;
      r.index = idx[15:0];
      r.value = val[16:0];
      pending.push_back(r);
   endtask

   task automatic csr_write(bit [1:0] idx, bit [16:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 0;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending.size() != 0 || req_tvalid || expected_answers.size() != 0);
      repeat (50) @(negedge clock);
   endtask

   // loads a whole bwt of len rows, its counts and its samples; consistent counts give a permutation
   task automatic load_text(int unsigned len, int unsigned iv, bit [3:0] sent, bit consistent);
      bit [3:0] sym;
      int unsigned below [17];
      int unsigned srow, ivx;
      ivx = iv == 0 ? 1 : iv;
      srow = $urandom_range(len - 1);
      foreach (below[k]) below[k] = 0;
      for (int unsigned p = 0; p < len; p++) begin
         if (p == srow) begin
            sym = sent;
         end else begin
            do sym = 4'($urandom_range(15)); while (sym == sent);
            for (int k = sym + 1; k < 17; k++) below[k]++;
         end
         push(fmil_pkg::OP_WR_BWT, p, {13'($urandom_range(8191)), sym});
      end
      for (int c = 0; c < 16; c++)
         push(fmil_pkg::OP_WR_CNT, c, consistent ? below[c] + 1 : $urandom_range(17'h1FFFF));
      for (int unsigned s = 0; s <= (len - 1) / ivx; s++)
         push(fmil_pkg::OP_WR_SAMP, s,
              {1'($urandom_range(1)), 16'($urandom_range(len - 1))});
   endtask

   task automatic random_locates(int unsigned len, int n);
      for (int i = 0; i < n; i++) begin
         int unsigned r;
         r = $urandom_range(99);
         if (r < 4 && len < 65536)
            push(fmil_pkg::OP_LOCATE, $urandom_range(65535, len), $urandom_range(17'h1FFFF));
         else if (r < 7)
            push(fmil_pkg::OP_WR_CNT, $urandom_range(65535, 16), $urandom_range(17'h1FFFF));
         else if (r < 10)
            push(fmil_pkg::OP_WR_BWT, $urandom_range(len - 1), $urandom_range(17'h1FFFF));
         else
            push(fmil_pkg::OP_LOCATE, $urandom_range(len - 1), $urandom_range(17'h1FFFF));
      end
   endtask

   task automatic run_phase(int unsigned iv, int unsigned len, bit [3:0] sent,
                            bit consistent, int n, bit quiet);
      drain();
      calm = quiet;
      csr_write(fmil_pkg::REG_INTERVAL, 17'(iv));
      csr_write(fmil_pkg::REG_LENGTH, 17'(len));
      csr_write(fmil_pkg::REG_SENTINEL, 17'(sent));
      @(posedge clock);
      load_text(len, iv, sent, consistent);
      random_locates(len, n);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, ignored writes, out-of-range rows
      run_phase(4, 16, 0, 1, 0, 0);
      push(fmil_pkg::OP_LOCATE, 0, 0);
      push(fmil_pkg::OP_LOCATE, 15, 17'h1FFFF);
      push(fmil_pkg::OP_LOCATE, 16, 0);
      push(fmil_pkg::OP_LOCATE, 65535, 17'h1FFFF);
      push(fmil_pkg::OP_WR_CNT, 16, 17'h1FFFF);
      push(fmil_pkg::OP_WR_CNT, 65535, 17'h1FFFF);
      push(fmil_pkg::OP_WR_SAMP, 65535, 17'h1FFFF);
      for (int i = 1; i < 15; i++) push(fmil_pkg::OP_LOCATE, i, 0);
      push(fmil_pkg::OP_WR_BWT, 15, 17'h1FFFF);
      push(fmil_pkg::OP_LOCATE, 15, 0);
      push(fmil_pkg::OP_LOCATE, 14, 0);
      run_phase(1, 40, 5, 1, 100, 0);
      run_phase(256, 300, 15, 1, 120, 0);
      run_phase(0, 24, 9, 1, 80, 0);
      run_phase(7, 100, 3, 0, 100, 0);
      run_phase(32, 1, 0, 1, 30, 0);
      run_phase(13, 60, 12, 1, 150, 1);
      run_phase(3, 64, 2, 1, 150, 0);
      drain();
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("fm_index_locate: match");
      else
         $display("fm_index_locate: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
